FILE: hw/rtl/evd_pkg.sv
`default_nettype none

package evd_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_STRING_COUNT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_COUNT   = 8'd1;

    localparam logic [4:0] TYPE_BYTE    = 5'h00;
    localparam logic [4:0] TYPE_SHORT   = 5'h02;
    localparam logic [4:0] TYPE_CHAR    = 5'h03;
    localparam logic [4:0] TYPE_INT     = 5'h04;
    localparam logic [4:0] TYPE_LONG    = 5'h06;
    localparam logic [4:0] TYPE_FLOAT   = 5'h10;
    localparam logic [4:0] TYPE_DOUBLE  = 5'h11;
    localparam logic [4:0] TYPE_STRING  = 5'h17;
    localparam logic [4:0] TYPE_TYPE    = 5'h18;
    localparam logic [4:0] TYPE_NULL    = 5'h1e;
    localparam logic [4:0] TYPE_BOOLEAN = 5'h1f;

    localparam logic [3:0] KIND_BYTE    = 4'd0;
    localparam logic [3:0] KIND_SHORT   = 4'd1;
    localparam logic [3:0] KIND_CHAR    = 4'd2;
    localparam logic [3:0] KIND_INT     = 4'd3;
    localparam logic [3:0] KIND_LONG    = 4'd4;
    localparam logic [3:0] KIND_FLOAT   = 4'd5;
    localparam logic [3:0] KIND_DOUBLE  = 4'd6;
    localparam logic [3:0] KIND_STRING  = 4'd7;
    localparam logic [3:0] KIND_TYPE    = 4'd8;
    localparam logic [3:0] KIND_NULL    = 4'd9;
    localparam logic [3:0] KIND_BOOLEAN = 4'd10;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SIZE        = 3'd1;
    localparam logic [2:0] ST_INDEX_RANGE = 3'd2;
    localparam logic [2:0] ST_NULL_SIZE   = 3'd3;
    localparam logic [2:0] ST_BAD_BOOLEAN = 3'd4;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd5;
    localparam logic [2:0] ST_TRUNCATED   = 3'd6;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_COLLECT = 2'd1,
        PH_SKIP    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         value_kind;
        logic signed [63:0] integral_value;
        logic [63:0]        float_bits;
        logic [31:0]        index_value;
        logic [2:0]         status;
    } out_item_t;

    function automatic logic [3:0] max_size(input logic [4:0] type_code);
        logic [3:0] size;
        case (type_code)
            TYPE_BYTE:                                        size = 4'd1;
            TYPE_SHORT, TYPE_CHAR:                            size = 4'd2;
            TYPE_INT, TYPE_FLOAT, TYPE_STRING, TYPE_TYPE:     size = 4'd4;
            TYPE_LONG, TYPE_DOUBLE:                           size = 4'd8;
            default:                                          size = 4'd0;
        endcase
        return size;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/encoded_value_decoder_core.sv
`default_nettype none

// Byte-serial decoder for encoded values: one byte is taken per clock cycle
// while the output is not stalled. A byte is first held in the input register;
// the byte finishing a value then loads the result register when it is decoded,
// and the result is offered from there. Each byte is decoded combinationally
// against the running accumulator, which sets that rate. Errors give one
// result with only status set, after which bytes are dropped through the one
// marked end_of_data. Configuration writes are accepted at any time but must
// only be made while the block is idle.
module encoded_value_decoder_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire evd_pkg::in_item_t                   in_item,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output evd_pkg::out_item_t                       out_item,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [evd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [evd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [31:0]         string_count_reg;
    logic [31:0]         type_count_reg;

    logic                in_valid_reg;
    evd_pkg::in_item_t   in_reg;

    evd_pkg::phase_t     phase_reg, phase_next;
    logic [4:0]          held_type_reg, held_type_next;
    logic [3:0]          held_size_reg, held_size_next;
    logic [3:0]          taken_reg, taken_next;
    logic [63:0]         acc_reg, acc_next;

    logic                out_valid_reg;
    evd_pkg::out_item_t  out_reg;

    logic                advance;
    logic [7:0]          b;
    logic                last;
    logic [4:0]          hdr_type;
    logic [2:0]          hdr_arg;
    logic [3:0]          hdr_size;
    logic [3:0]          hdr_max;
    logic [63:0]         acc_new;
    logic [3:0]          taken_inc;
    logic                collect_done;
    logic [63:0]         sext;
    logic [3:0]          float_gap;
    logic [3:0]          double_gap;
    logic [31:0]         float_shifted;
    logic [63:0]         double_shifted;

    logic                res_valid;
    evd_pkg::out_item_t  res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            string_count_reg <= '0;
            type_count_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                evd_pkg::REG_STRING_COUNT: string_count_reg <= cfg_data;
                evd_pkg::REG_TYPE_COUNT:   type_count_reg   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_item;
        end
    end

    assign b         = in_reg.data_byte;
    assign last      = in_reg.end_of_data;
    assign hdr_type  = b[4:0];
    assign hdr_arg   = b[7:5];
    assign hdr_size  = {1'b0, hdr_arg} + 4'd1;
    assign hdr_max   = evd_pkg::max_size(hdr_type);

    assign acc_new      = acc_reg | (64'(b) << {taken_reg[2:0], 3'b000});
    assign taken_inc    = taken_reg + 4'd1;
    assign collect_done = taken_inc >= held_size_reg;

    always_comb
    begin
        case (held_size_reg)
            4'd1:    sext = {{56{acc_new[7]}}, acc_new[7:0]};
            4'd2:    sext = {{48{acc_new[15]}}, acc_new[15:0]};
            4'd3:    sext = {{40{acc_new[23]}}, acc_new[23:0]};
            4'd4:    sext = {{32{acc_new[31]}}, acc_new[31:0]};
            4'd5:    sext = {{24{acc_new[39]}}, acc_new[39:0]};
            4'd6:    sext = {{16{acc_new[47]}}, acc_new[47:0]};
            4'd7:    sext = {{8{acc_new[55]}}, acc_new[55:0]};
            default: sext = acc_new;
        endcase
    end

    assign float_gap      = 4'd4 - held_size_reg;
    assign double_gap     = 4'd8 - held_size_reg;
    assign float_shifted  = acc_new[31:0] << {float_gap[1:0], 3'b000};
    assign double_shifted = acc_new << {double_gap[2:0], 3'b000};

    // Result of the byte in the decode stage.
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        case (phase_reg)
            evd_pkg::PH_SKIP:
            begin
                res_valid = 1'b0;
            end
            evd_pkg::PH_COLLECT:
            begin
                if (collect_done)
                begin
                    res_valid = 1'b1;
                    case (held_type_reg)
                        evd_pkg::TYPE_BYTE:
                        begin
                            res.value_kind     = evd_pkg::KIND_BYTE;
                            res.integral_value = sext;
                        end
                        evd_pkg::TYPE_SHORT:
                        begin
                            res.value_kind     = evd_pkg::KIND_SHORT;
                            res.integral_value = sext;
                        end
                        evd_pkg::TYPE_CHAR:
                        begin
                            res.value_kind     = evd_pkg::KIND_CHAR;
                            res.integral_value = acc_new;
                        end
                        evd_pkg::TYPE_INT:
                        begin
                            res.value_kind     = evd_pkg::KIND_INT;
                            res.integral_value = sext;
                        end
                        evd_pkg::TYPE_LONG:
                        begin
                            res.value_kind     = evd_pkg::KIND_LONG;
                            res.integral_value = sext;
                        end
                        evd_pkg::TYPE_FLOAT:
                        begin
                            res.value_kind = evd_pkg::KIND_FLOAT;
                            res.float_bits = {32'd0, float_shifted};
                        end
                        evd_pkg::TYPE_DOUBLE:
                        begin
                            res.value_kind = evd_pkg::KIND_DOUBLE;
                            res.float_bits = double_shifted;
                        end
                        evd_pkg::TYPE_STRING:
                        begin
                            if (acc_new[31:0] >= string_count_reg)
                            begin
                                res.status = evd_pkg::ST_INDEX_RANGE;
                            end
                            else
                            begin
                                res.value_kind  = evd_pkg::KIND_STRING;
                                res.index_value = acc_new[31:0];
                            end
                        end
                        default:
                        begin
                            if (acc_new[31:0] >= type_count_reg)
                            begin
                                res.status = evd_pkg::ST_INDEX_RANGE;
                            end
                            else
                            begin
                                res.value_kind  = evd_pkg::KIND_TYPE;
                                res.index_value = acc_new[31:0];
                            end
                        end
                    endcase
                end
                else if (last)
                begin
                    res_valid  = 1'b1;
                    res.status = evd_pkg::ST_TRUNCATED;
                end
            end
            default:
            begin
                res_valid = 1'b1;
                if (hdr_type == evd_pkg::TYPE_NULL)
                begin
                    if (hdr_arg != 3'd0)
                    begin
                        res.status = evd_pkg::ST_NULL_SIZE;
                    end
                    else
                    begin
                        res.value_kind = evd_pkg::KIND_NULL;
                    end
                end
                else if (hdr_type == evd_pkg::TYPE_BOOLEAN)
                begin
                    if (hdr_arg > 3'd1)
                    begin
                        res.status = evd_pkg::ST_BAD_BOOLEAN;
                    end
                    else
                    begin
                        res.value_kind     = evd_pkg::KIND_BOOLEAN;
                        res.integral_value = 64'(hdr_arg);
                    end
                end
                else if (hdr_max == 4'd0)
                begin
                    res.status = evd_pkg::ST_UNSUPPORTED;
                end
                else if (hdr_size > hdr_max)
                begin
                    res.status = evd_pkg::ST_SIZE;
                end
                else if (last)
                begin
                    res.status = evd_pkg::ST_TRUNCATED;
                end
                else
                begin
                    res_valid = 1'b0;
                end
            end
        endcase
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            if (res_valid)
            begin
                if (res.status != evd_pkg::ST_OK && !last)
                begin
                    phase_next = evd_pkg::PH_SKIP;
                end
                else
                begin
                    phase_next = evd_pkg::PH_HEADER;
                end
            end
            else
            begin
                case (phase_reg)
                    evd_pkg::PH_SKIP:
                    begin
                        phase_next = last ? evd_pkg::PH_HEADER : evd_pkg::PH_SKIP;
                    end
                    default:
                    begin
                        phase_next = evd_pkg::PH_COLLECT;
                    end
                endcase
            end
        end
    end

    // Next value of the held header fields and the accumulator.
    always_comb
    begin
        held_type_next = held_type_reg;
        held_size_next = held_size_reg;
        taken_next     = taken_reg;
        acc_next       = acc_reg;
        if (advance)
        begin
            case (phase_reg)
                evd_pkg::PH_SKIP:
                begin
                    acc_next = acc_reg;
                end
                evd_pkg::PH_COLLECT:
                begin
                    acc_next   = acc_new;
                    taken_next = taken_inc;
                end
                default:
                begin
                    held_type_next = hdr_type;
                    held_size_next = res_valid ? 4'd0 : hdr_size;
                    taken_next     = 4'd0;
                    acc_next       = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= evd_pkg::PH_HEADER;
            held_type_reg <= '0;
            held_size_reg <= '0;
            taken_reg     <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            held_type_reg <= held_type_next;
            held_size_reg <= held_size_next;
            taken_reg     <= taken_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // While collecting, the held size is a legal payload length and more bytes are due.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == evd_pkg::PH_COLLECT |->
            held_size_reg != 4'd0 && held_size_reg <= 4'd8 && taken_reg < held_size_reg)
        else $error("collect state holds an impossible size or byte count");

    // An error result carries nothing but its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status != evd_pkg::ST_OK |->
            out_reg.value_kind == 4'd0 && out_reg.integral_value == 64'sd0 &&
            out_reg.float_bits == 64'd0 && out_reg.index_value == 32'd0)
        else $error("error result has a nonzero value field");

    // A byte waiting in the input register is neither lost nor changed.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("stalled input byte was dropped or altered");

    // A truncation is only reported on a byte that ends the buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid && res.status == evd_pkg::ST_TRUNCATED |-> last)
        else $error("truncation reported without end of data");

    // Leaving the skip state requires the end-of-data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == evd_pkg::PH_SKIP && phase_next != evd_pkg::PH_SKIP |->
            advance && last)
        else $error("skip state left before end of data");

endmodule

`default_nettype wire
